FILE: rtl/core/keyframe_vector_interpolation_assert.svh
// assertion macros for the keyframe interpolation block
`ifndef KEYFRAME_VECTOR_INTERPOLATION_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KVI_ASSERT_IMPLY(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KVI_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/kvi_pkg.sv
// shared constants, types and states of the keyframe interpolation block
package kvi_pkg;

  // table size and index widths
  localparam int KEYS    = 64;
  localparam int IDX_W   = $clog2(KEYS);
  localparam int KEY_N_W = $clog2(KEYS + 1);

  // field widths
  localparam int CFG_W   = 7;
  localparam int SLOT_W  = 6;
  localparam int SEG_W   = 6;
  localparam int TIME_W  = 32;
  localparam int VAL_W   = 32;
  localparam int NCOMP   = 3;
  localparam int COMP_W  = $clog2(NCOMP);
  localparam int VEC_W   = NCOMP * VAL_W;

  // fraction format of the blend factor
  localparam int FRAC_BITS = 16;
  localparam int FACTOR_W  = FRAC_BITS + 1;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // blend unit phases
  localparam logic [1:0] PH_DIFF = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_SUM  = 2'd2;

  typedef logic [VAL_W-1:0] comp_t;
  typedef comp_t [NCOMP-1:0] vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE,
    ST_READ_S,
    ST_READ_E,
    ST_START,
    ST_BLEND,
    ST_EMIT
  } kvi_state_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [FACTOR_W-1:0] factor;
    vec_t                s_vec;
    vec_t                e_vec;
  } lerp_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    vec_t res;
  } lerp_rsp_t;

endpackage

FILE: rtl/core/kvi_in_if.sv
// input channel: load and query items
interface kvi_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic        [kvi_pkg::SLOT_W-1:0]  key_slot;
  logic        [kvi_pkg::TIME_W-1:0]  key_time;
  logic signed [kvi_pkg::VAL_W-1:0]   key_x;
  logic signed [kvi_pkg::VAL_W-1:0]   key_y;
  logic signed [kvi_pkg::VAL_W-1:0]   key_z;
  logic        [kvi_pkg::TIME_W-1:0]  query_time;

  modport source (
    output valid, op, key_slot, key_time, key_x, key_y, key_z, query_time,
    input  ready
  );
  modport sink (
    input  valid, op, key_slot, key_time, key_x, key_y, key_z, query_time,
    output ready
  );
endinterface

FILE: rtl/core/kvi_out_if.sv
// output channel: interpolated vectors
interface kvi_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [kvi_pkg::VAL_W-1:0] out_x;
  logic signed [kvi_pkg::VAL_W-1:0] out_y;
  logic signed [kvi_pkg::VAL_W-1:0] out_z;
  logic        [kvi_pkg::SEG_W-1:0] segment;

  modport source (
    output valid, out_x, out_y, out_z, segment,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, segment,
    output ready
  );
endinterface

FILE: rtl/core/kvi_ram.sv
// generic single-port-write, single-port-read ram with registered read
module kvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/kvi_div.sv
// restoring divider for the blend factor, one quotient bit per cycle
module kvi_div (
  input  logic              clk,
  input  logic              rst,
  input  kvi_pkg::div_req_t req,
  output kvi_pkg::div_rsp_t rsp
);

  logic [kvi_pkg::TIME_W-1:0]    rem;
  logic [kvi_pkg::TIME_W-1:0]    den;
  logic [kvi_pkg::FRAC_BITS-1:0] quot;
  logic [kvi_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [kvi_pkg::TIME_W:0]      shifted;
  logic [kvi_pkg::TIME_W:0]      diff;
  logic                          ge;

  // one trial subtraction; the remainder stays below the divisor when the dividend starts below it
  always_comb begin
    shifted = {rem, 1'b0};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == kvi_pkg::DIV_CNT_W'(kvi_pkg::FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      rem  <= ge ? diff[kvi_pkg::TIME_W-1:0] : shifted[kvi_pkg::TIME_W-1:0];
      quot <= {quot[kvi_pkg::FRAC_BITS-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quot = quot;

endmodule

FILE: rtl/core/kvi_lerp.sv
// blend unit: one shared multiplier, one component at a time
module kvi_lerp (
  input  logic               clk,
  input  logic               rst,
  input  kvi_pkg::lerp_req_t req,
  output kvi_pkg::lerp_rsp_t rsp
);

  localparam int DIFF_W = kvi_pkg::VAL_W + 1;
  localparam int PROD_W = DIFF_W + kvi_pkg::FACTOR_W + 1;
  localparam int Q_W    = PROD_W - kvi_pkg::FRAC_BITS;

  kvi_pkg::vec_t                   s_vec;
  kvi_pkg::vec_t                   e_vec;
  kvi_pkg::vec_t                   res;
  logic [kvi_pkg::FACTOR_W-1:0]    factor;
  logic [kvi_pkg::COMP_W-1:0]      comp;
  logic [1:0]                      phase;
  logic                            busy;
  logic                            done;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [PROD_W-1:0]        prod;
  logic signed [Q_W-1:0]           quo;
  logic signed [Q_W-1:0]           sum;
  logic [kvi_pkg::VAL_W-1:0]       sat;
  logic signed [DIFF_W-1:0]        s_ext;
  logic signed [DIFF_W-1:0]        e_ext;

  // sign-extended operands of the current component
  always_comb begin
    s_ext = DIFF_W'($signed(s_vec[comp]));
    e_ext = DIFF_W'($signed(e_vec[comp]));
  end

  // floor of product over one, added to the start value, then saturated
  always_comb begin
    quo = prod[PROD_W-1:kvi_pkg::FRAC_BITS];
    sum = Q_W'(s_ext) + quo;
    if (!sum[Q_W-1] && (sum[Q_W-2:kvi_pkg::VAL_W-1] != '0)) begin
      sat = {1'b0, {(kvi_pkg::VAL_W-1){1'b1}}};
    end else if (sum[Q_W-1] && (sum[Q_W-2:kvi_pkg::VAL_W-1] != '1)) begin
      sat = {1'b1, {(kvi_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat = sum[kvi_pkg::VAL_W-1:0];
    end
  end

  // phase sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      comp  <= '0;
      phase <= kvi_pkg::PH_DIFF;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        comp  <= '0;
        phase <= kvi_pkg::PH_DIFF;
      end else if (busy) begin
        case (phase)
          kvi_pkg::PH_DIFF: phase <= kvi_pkg::PH_MUL;
          kvi_pkg::PH_MUL:  phase <= kvi_pkg::PH_SUM;
          kvi_pkg::PH_SUM: begin
            phase <= kvi_pkg::PH_DIFF;
            if (comp == kvi_pkg::COMP_W'(kvi_pkg::NCOMP - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              comp <= comp + 1'b1;
            end
          end
          default: phase <= kvi_pkg::PH_DIFF;
        endcase
      end
    end
  end

  // datapath: difference, product, sum
  always_ff @(posedge clk) begin
    if (req.start) begin
      s_vec  <= req.s_vec;
      e_vec  <= req.e_vec;
      factor <= req.factor;
    end else if (busy) begin
      case (phase)
        kvi_pkg::PH_DIFF: diff <= e_ext - s_ext;
        kvi_pkg::PH_MUL:  prod <= PROD_W'(diff * $signed({1'b0, factor}));
        kvi_pkg::PH_SUM: begin
          // zero factor returns the start key untouched
          res[comp] <= (factor == '0) ? s_vec[comp] : sat;
        end
        default: ;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.res  = res;

endmodule

FILE: rtl/core/keyframe_vector_interpolation.sv
// keyframe interpolation top level: key tables, segment scan and sequencer
//
// Use: items arrive on the item channel (valid/ready, a transfer when both
// are high). A load item (op 0) writes one key into the time and vector
// tables in the cycle of its transfer and gives no result. A query item
// (op 1) gives one result on the result channel: the start key blended
// toward the next key of the segment that holds the query time, and the
// segment index. key_count is written through cfg_write_en/cfg_write_data.
// A query on more than one key walks the time table one key per cycle
// through its read port; when the query time lies strictly inside a
// segment it then runs a 16-step divider for the factor. Every query reads
// both keys from the vector table and blends x, y and z through one shared
// multiplier, in a difference, product and sum phase per component. The
// item channel is ready only between queries.
// Reset clears the sequencer and sets key_count to 1; table contents are
// undefined until loaded. When the receiver stalls, the finished result
// waits in the output register and loads keep being taken; the next query
// then holds at its end until the output register frees.
`include "keyframe_vector_interpolation_assert.svh"

module keyframe_vector_interpolation (
  input  logic                        clk,
  input  logic                        rst,
  kvi_in_if.sink                      item,
  kvi_out_if.source                   result,
  input  logic                        cfg_write_en,
  input  logic [kvi_pkg::CFG_W-1:0]   cfg_write_data
);

  kvi_pkg::kvi_state_t            state;
  kvi_pkg::kvi_state_t            state_next;

  logic [kvi_pkg::CFG_W-1:0]      key_count;
  logic [kvi_pkg::KEY_N_W-1:0]    n_clamp;
  logic [kvi_pkg::KEY_N_W-1:0]    n_keys;
  logic [kvi_pkg::TIME_W-1:0]     qtime;
  logic [kvi_pkg::TIME_W-1:0]     t1;
  logic [kvi_pkg::IDX_W-1:0]      idx;
  logic [kvi_pkg::IDX_W-1:0]      seg;
  logic [kvi_pkg::FACTOR_W-1:0]   factor;
  kvi_pkg::vec_t                  s_vec;
  kvi_pkg::vec_t                  out_vec;
  logic [kvi_pkg::SEG_W-1:0]      out_seg;
  logic                           out_valid;

  logic                           in_ready;
  logic                           item_xfer;
  logic                           load_we;
  logic [kvi_pkg::IDX_W-1:0]      waddr;
  logic [kvi_pkg::IDX_W-1:0]      time_raddr;
  logic [kvi_pkg::IDX_W-1:0]      vec_raddr;
  logic [kvi_pkg::TIME_W-1:0]     time_rdata;
  kvi_pkg::vec_t                  vec_rdata;
  kvi_pkg::vec_t                  vec_wdata;

  logic                           single;
  logic                           scan_first;
  logic                           scan_hit;
  logic                           scan_last;
  logic                           zero_span;
  logic                           out_free;
  logic                           out_load;

  kvi_pkg::div_req_t              div_req;
  kvi_pkg::div_rsp_t              div_rsp;
  kvi_pkg::lerp_req_t             lerp_req;
  kvi_pkg::lerp_rsp_t             lerp_rsp;

  // key tables: loads never overlap a query, so no forwarding is needed
  assign item_xfer = item.valid && in_ready;
  assign load_we   = item_xfer && (item.op == kvi_pkg::OP_LOAD)
                     && (int'(item.key_slot) < kvi_pkg::KEYS);
  assign waddr     = kvi_pkg::IDX_W'(item.key_slot);
  assign vec_wdata = {item.key_z, item.key_y, item.key_x};

  kvi_ram #(.WIDTH(kvi_pkg::TIME_W), .DEPTH(kvi_pkg::KEYS)) u_time_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (item.key_time),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  kvi_ram #(.WIDTH(kvi_pkg::VEC_W), .DEPTH(kvi_pkg::KEYS)) u_vec_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  kvi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  kvi_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .req (lerp_req),
    .rsp (lerp_rsp)
  );

  // key count register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvi_pkg::CFG_W'(1);
    end else if (cfg_write_en) begin
      key_count <= cfg_write_data;
    end
  end

  // clamp the key count to 1..KEYS
  always_comb begin
    if (key_count == '0) begin
      n_clamp = kvi_pkg::KEY_N_W'(1);
    end else if (int'(key_count) > kvi_pkg::KEYS) begin
      n_clamp = kvi_pkg::KEY_N_W'(kvi_pkg::KEYS);
    end else begin
      n_clamp = kvi_pkg::KEY_N_W'(key_count);
    end
  end

  // scan decisions on the time word read back this cycle
  assign single     = (n_clamp == kvi_pkg::KEY_N_W'(1));
  assign scan_first = (idx == '0);
  assign scan_hit   = qtime < time_rdata;
  assign scan_last  = (kvi_pkg::KEY_N_W'(idx) + 1'b1) == n_keys;
  assign zero_span  = (qtime <= t1) || (time_rdata <= t1);
  assign out_free   = !out_valid || result.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kvi_pkg::ST_IDLE: begin
        if (item_xfer && (item.op == kvi_pkg::OP_QUERY)) begin
          state_next = single ? kvi_pkg::ST_READ_S : kvi_pkg::ST_SCAN;
        end
      end
      kvi_pkg::ST_SCAN: begin
        if (!scan_first) begin
          if (scan_hit) begin
            state_next = zero_span ? kvi_pkg::ST_READ_S : kvi_pkg::ST_DIVIDE;
          end else if (scan_last) begin
            state_next = kvi_pkg::ST_READ_S;
          end
        end
      end
      kvi_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = kvi_pkg::ST_READ_S;
        end
      end
      kvi_pkg::ST_READ_S: state_next = kvi_pkg::ST_READ_E;
      kvi_pkg::ST_READ_E: state_next = kvi_pkg::ST_START;
      kvi_pkg::ST_START:  state_next = kvi_pkg::ST_BLEND;
      kvi_pkg::ST_BLEND: begin
        if (lerp_rsp.done) begin
          state_next = kvi_pkg::ST_EMIT;
        end
      end
      kvi_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = kvi_pkg::ST_IDLE;
        end
      end
      default: state_next = kvi_pkg::ST_IDLE;
    endcase
  end

  // state-driven outputs
  always_comb begin
    in_ready       = 1'b0;
    time_raddr     = '0;
    vec_raddr      = seg;
    div_req.start  = 1'b0;
    lerp_req.start = 1'b0;
    out_load       = 1'b0;
    case (state)
      kvi_pkg::ST_IDLE: in_ready = 1'b1;
      kvi_pkg::ST_SCAN: begin
        time_raddr    = idx + 1'b1;
        div_req.start = !scan_first && scan_hit && !zero_span;
      end
      kvi_pkg::ST_READ_S: vec_raddr = seg;
      kvi_pkg::ST_READ_E: vec_raddr = seg + 1'b1;
      kvi_pkg::ST_START:  lerp_req.start = 1'b1;
      kvi_pkg::ST_EMIT:   out_load = out_free;
      default: ;
    endcase
  end

  assign div_req.dividend = qtime - t1;
  assign div_req.divisor  = time_rdata - t1;
  assign lerp_req.factor  = factor;
  assign lerp_req.s_vec   = s_vec;
  assign lerp_req.e_vec   = vec_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      kvi_pkg::ST_IDLE: begin
        if (item_xfer && (item.op == kvi_pkg::OP_QUERY)) begin
          qtime  <= item.query_time;
          n_keys <= n_clamp;
          idx    <= '0;
          seg    <= '0;
          factor <= '0;
        end
      end
      kvi_pkg::ST_SCAN: begin
        if (scan_first) begin
          t1  <= time_rdata;
          idx <= idx + 1'b1;
        end else if (scan_hit) begin
          seg    <= idx - 1'b1;
          factor <= '0;
        end else if (scan_last) begin
          // past the last key: end of the final segment
          seg    <= idx - 1'b1;
          factor <= kvi_pkg::FACTOR_ONE;
        end else begin
          t1  <= time_rdata;
          idx <= idx + 1'b1;
        end
      end
      kvi_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          factor <= {1'b0, div_rsp.quot};
        end
      end
      kvi_pkg::ST_READ_E: s_vec <= vec_rdata;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vec <= lerp_rsp.res;
      out_seg <= kvi_pkg::SEG_W'(seg);
    end
  end

  assign item.ready     = in_ready;
  assign result.valid   = out_valid;
  assign result.out_x   = out_vec[0];
  assign result.out_y   = out_vec[1];
  assign result.out_z   = out_vec[2];
  assign result.segment = out_seg;

  // checks on the sequencer
  `KVI_ASSERT_IMPLY(a_scan_in_range, clk, rst, state == kvi_pkg::ST_SCAN,
    kvi_pkg::KEY_N_W'(idx) < n_keys, "scan index ran past the key count")
  `KVI_ASSERT_IMPLY(a_div_idle_on_start, clk, rst, div_req.start,
    !div_rsp.busy, "divider started while busy")
  `KVI_ASSERT_IMPLY(a_blend_done_in_blend, clk, rst, lerp_rsp.done,
    state == kvi_pkg::ST_BLEND, "blend finished outside the blend state")
  `KVI_ASSERT_NEXT(a_emit_holds, clk, rst,
    (state == kvi_pkg::ST_EMIT) && out_valid && !result.ready,
    state == kvi_pkg::ST_EMIT, "finished query left while output was full")

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the keyframe vector interpolation block
`timescale 1ns / 100ps

module testbench;
  import kvi_pkg::*;

  localparam int SETTLE_CYCLES    = 110;
  localparam int HOLD_CYCLES      = 400;
  localparam int NUM_PHASES       = 20;
  localparam int ITEMS_PER_PHASE  = 45;
  localparam int MAX_SHOWN        = 10;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] ktime;
    comp_t             kx;
    comp_t             ky;
    comp_t             kz;
    logic [TIME_W-1:0] qtime;
  } key_item_t;

  typedef struct packed {
    comp_t            x;
    comp_t            y;
    comp_t            z;
    logic [SEG_W-1:0] seg;
  } blend_res_t;

  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] cfg_val;
    key_item_t        it;
    logic             typed;
    blend_res_t       want;
  } step_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_write_en;
  logic [CFG_W-1:0] cfg_write_data;

  kvi_in_if  item_ch ();
  kvi_out_if result_ch ();

  keyframe_vector_interpolation i_dut (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .result         (result_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // shadow of the key tables and the key count
  logic [TIME_W-1:0] key_time_tbl [KEYS];
  comp_t             key_x_tbl    [KEYS];
  comp_t             key_y_tbl    [KEYS];
  comp_t             key_z_tbl    [KEYS];
  logic [CFG_W-1:0]  key_count_shadow;

  blend_res_t pending_blends [$];
  step_row_t  directed_plan [$];

  // pacing controls
  bit gaps_on;
  bit stalls_on;
  int burst_left;
  int hold_asked;
  int hold_seen;
  int hold_left;
  int stall_left;

  // run statistics
  int n_loads;
  int n_queries;
  int n_checked;
  int n_cfg;
  int n_faults;

  blend_res_t got_res;
  blend_res_t want_res;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // effective number of keys, the count clamped to 1..KEYS
  function automatic int unsigned eff_keys();
    int unsigned n;
    n = key_count_shadow;
    if (n < 1) n = 1;
    if (n > KEYS) n = KEYS;
    return n;
  endfunction

  // start + factor * (end - start), product floored, sum saturated
  function automatic comp_t blend_component(comp_t s, comp_t e, logic [FACTOR_W-1:0] f);
    longint sv;
    longint ev;
    longint p;
    longint r;
    sv = longint'($signed(s));
    ev = longint'($signed(e));
    p  = (ev - sv) * longint'(f);
    r  = sv + (p >>> FRAC_BITS);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return comp_t'(r);
  endfunction

  // segment scan, blend factor and vector blend for one query time
  function automatic blend_res_t interpolate_keys(logic [TIME_W-1:0] t);
    blend_res_t           res;
    int unsigned          n;
    int unsigned          seg;
    int unsigned          i;
    bit                   found;
    logic [FACTOR_W-1:0]  factor;
    logic [TIME_W-1:0]    t1;
    logic [TIME_W-1:0]    t2;
    logic [TIME_W-1:0]    dt;
    logic [63:0]          num;
    logic [63:0]          quo;
    n = eff_keys();
    if (n == 1) begin
      res.x   = key_x_tbl[0];
      res.y   = key_y_tbl[0];
      res.z   = key_z_tbl[0];
      res.seg = '0;
      return res;
    end
    seg   = n - 2;
    found = 1'b0;
    for (i = 0; i + 1 < n; i++) begin
      if (!found && t < key_time_tbl[i+1]) begin
        seg   = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      factor = FACTOR_ONE;
    end else begin
      t1 = key_time_tbl[seg];
      t2 = key_time_tbl[seg+1];
      if (t <= t1 || t2 <= t1) begin
        factor = '0;
      end else begin
        dt  = t - t1;
        num = {32'b0, dt} << FRAC_BITS;
        quo = num / {32'b0, t2 - t1};
        factor = (quo > 64'd65536) ? FACTOR_ONE : quo[FACTOR_W-1:0];
      end
    end
    res.x   = blend_component(key_x_tbl[seg], key_x_tbl[seg+1], factor);
    res.y   = blend_component(key_y_tbl[seg], key_y_tbl[seg+1], factor);
    res.z   = blend_component(key_z_tbl[seg], key_z_tbl[seg+1], factor);
    res.seg = seg[SEG_W-1:0];
    return res;
  endfunction

  // table rows
  function automatic blend_res_t mk_res(comp_t x, comp_t y, comp_t z, logic [SEG_W-1:0] seg);
    blend_res_t r;
    r.x   = x;
    r.y   = y;
    r.z   = z;
    r.seg = seg;
    return r;
  endfunction

  function automatic step_row_t row_load(logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] t,
                                         comp_t x, comp_t y, comp_t z);
    step_row_t r;
    r          = '0;
    r.it.op    = OP_LOAD;
    r.it.slot  = slot;
    r.it.ktime = t;
    r.it.kx    = x;
    r.it.ky    = y;
    r.it.kz    = z;
    r.it.qtime = $urandom;
    return r;
  endfunction

  function automatic step_row_t row_query(logic [TIME_W-1:0] t, logic typed, blend_res_t want);
    step_row_t r;
    r          = '0;
    r.it.op    = OP_QUERY;
    r.it.slot  = $urandom;
    r.it.ktime = $urandom;
    r.it.kx    = $urandom;
    r.it.ky    = $urandom;
    r.it.kz    = $urandom;
    r.it.qtime = t;
    r.typed    = typed;
    r.want     = want;
    return r;
  endfunction

  function automatic step_row_t row_cfg(logic [CFG_W-1:0] v);
    step_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  // random field values with extra weight on the extremes
  function automatic comp_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return comp_t'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0001_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned n;
    int unsigned k;
    n = eff_keys();
    k = (n > 1) ? $urandom_range(0, n - 2) : 0;
    case ($urandom_range(0, 9))
      0:       return (key_time_tbl[0] == 0) ? '0 : $urandom_range(0, key_time_tbl[0] - 1);
      1:       return key_time_tbl[$urandom_range(0, n - 1)];
      2:       return $urandom_range(key_time_tbl[n-1], 32'hFFFF_FFFF);
      3:       return $urandom;
      default: return $urandom_range(key_time_tbl[k], key_time_tbl[k+1]);
    endcase
  endfunction

  function automatic step_row_t random_load();
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] t;
    slot = $urandom_range(0, KEYS - 1);
    lo   = (slot > 0) ? key_time_tbl[slot-1] : '0;
    hi   = (slot < KEYS - 1) ? key_time_tbl[slot+1] : 32'hFFFF_FFFF;
    // mostly keep the table ordered, sometimes break the order
    t    = ($urandom_range(0, 4) != 0) ? $urandom_range(lo, hi) : $urandom;
    return row_load(slot, t, pick_value(), pick_value(), pick_value());
  endfunction

  // shadow update and expected result at a transfer on the item channel
  task automatic note_transfer(input key_item_t it, input logic typed, input blend_res_t want);
    if (it.op == OP_LOAD) begin
      key_time_tbl[it.slot] = it.ktime;
      key_x_tbl[it.slot]    = it.kx;
      key_y_tbl[it.slot]    = it.ky;
      key_z_tbl[it.slot]    = it.kz;
      n_loads++;
    end else begin
      pending_blends.push_back(typed ? want : interpolate_keys(it.qtime));
      n_queries++;
    end
  endtask

  // offer one item, in bursts with random gaps when enabled
  task automatic offer(input key_item_t it, input logic typed, input blend_res_t want);
    int gap;
    if (gaps_on) begin
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 12);
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= it.op;
    item_ch.key_slot   <= it.slot;
    item_ch.key_time   <= it.ktime;
    item_ch.key_x      <= it.kx;
    item_ch.key_y      <= it.ky;
    item_ch.key_z      <= it.kz;
    item_ch.query_time <= it.qtime;
    do @(posedge clk); while (!item_ch.ready);
    note_transfer(it, typed, want);
  endtask

  // stop sending, wait for every result, then let the block go quiet
  task automatic settle_idle();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(input logic [CFG_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    key_count_shadow = v;
    cfg_write_en <= 1'b0;
    n_cfg++;
  endtask

  // reload all slots with an ordered time line and random vectors
  task automatic refill_keys();
    step_row_t         r;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] step;
    int                s;
    t = ($urandom_range(0, 5) == 0) ? $urandom_range(32'hF000_0000, 32'hFFFF_FFFF)
                                    : $urandom_range(0, 32'h000F_FFFF);
    for (s = 0; s < KEYS; s++) begin
      r = row_load(s[SLOT_W-1:0], t, pick_value(), pick_value(), pick_value());
      offer(r.it, 1'b0, '0);
      step = ($urandom_range(0, 7) == 0) ? '0
           : ($urandom_range(1, 32'h03FF_FFFF) >> $urandom_range(0, 26));
      t = (32'hFFFF_FFFF - t < step) ? 32'hFFFF_FFFF : t + step;
    end
  endtask

  task automatic report_fault(input string what, input blend_res_t want, input blend_res_t got);
    n_faults++;
    if (n_faults <= MAX_SHOWN)
      $display("%s at %0t: expected x=%h y=%h z=%h seg=%0d, got x=%h y=%h z=%h seg=%0d",
               what, $realtime, want.x, want.y, want.z, want.seg,
               got.x, got.y, got.z, got.seg);
  endtask

  // result channel: check each transfer, then choose the next ready
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_res = mk_res(result_ch.out_x, result_ch.out_y, result_ch.out_z, result_ch.segment);
      if (pending_blends.size() == 0) begin
        report_fault("unexpected result", '0, got_res);
      end else begin
        want_res = pending_blends.pop_front();
        n_checked++;
        if (got_res !== want_res) report_fault("result mismatch", want_res, got_res);
      end
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (!stalls_on) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 9);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // run limit
  initial begin
    #6_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // main sequence
  initial begin
    step_row_t   r;
    int          ph;
    int          k;
    logic [CFG_W-1:0] cnt;
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_write_en       = 1'b0;
    cfg_write_data     = '0;
    item_ch.valid      = 1'b0;
    item_ch.op         = OP_LOAD;
    item_ch.key_slot   = '0;
    item_ch.key_time   = '0;
    item_ch.key_x      = '0;
    item_ch.key_y      = '0;
    item_ch.key_z      = '0;
    item_ch.query_time = '0;
    result_ch.ready    = 1'b0;
    key_count_shadow   = 7'd1;
    gaps_on            = 1'b1;
    stalls_on          = 1'b1;
    burst_left         = 0;
    hold_asked         = 0;
    hold_seen          = 0;
    hold_left          = 0;
    stall_left         = 0;
    n_loads            = 0;
    n_queries          = 0;
    n_checked          = 0;
    n_cfg              = 0;
    n_faults           = 0;

    // directed table; key count is one after reset
    directed_plan.push_back(row_load(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h0001_0000));
    // single key returns key 0 whatever the time
    directed_plan.push_back(row_query(32'h0000_0000, 1'b1,
                            mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6'd0)));
    directed_plan.push_back(row_query(32'hFFFF_FFFF, 1'b1,
                            mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6'd0)));
    directed_plan.push_back(row_load(6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'hFFFF_0000));
    directed_plan.push_back(row_load(6'd2, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000,
                                     32'h0000_0000));
    directed_plan.push_back(row_load(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                                     32'h8000_0000));
    // a count of zero behaves as one key
    directed_plan.push_back(row_cfg(7'd0));
    directed_plan.push_back(row_query(32'h0002_0000, 1'b1,
                            mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6'd0)));
    directed_plan.push_back(row_cfg(7'd2));
    // before and at the first key, at and past the last key
    directed_plan.push_back(row_query(32'h0000_0000, 1'b1,
                            mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6'd0)));
    directed_plan.push_back(row_query(32'h0001_0000, 1'b1,
                            mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6'd0)));
    directed_plan.push_back(row_query(32'h0003_0000, 1'b1,
                            mk_res(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 6'd0)));
    directed_plan.push_back(row_query(32'hFFFF_FFFF, 1'b1,
                            mk_res(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 6'd0)));
    // full-range blends inside the segment
    directed_plan.push_back(row_query(32'h0002_0000, 1'b0, '0));
    directed_plan.push_back(row_query(32'h0002_FFFF, 1'b0, '0));
    directed_plan.push_back(row_query(32'h0001_0001, 1'b0, '0));
    directed_plan.push_back(row_cfg(7'd3));
    // last two keys share a time: query there lands on the last key
    directed_plan.push_back(row_query(32'h0003_0000, 1'b1,
                            mk_res(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd1)));
    directed_plan.push_back(row_query(32'h0002_8000, 1'b0, '0));
    // first two keys share a time
    directed_plan.push_back(row_load(6'd1, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                     32'h7FFF_0000));
    directed_plan.push_back(row_query(32'h0001_0000, 1'b1,
                            mk_res(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_0000, 6'd1)));
    directed_plan.push_back(row_query(32'h0000_8000, 1'b1,
                            mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6'd0)));
    directed_plan.push_back(row_query(32'h0002_0000, 1'b0, '0));
    // key times out of order
    directed_plan.push_back(row_load(6'd2, 32'h0000_8000, 32'hFFFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF));
    directed_plan.push_back(row_query(32'h0000_C000, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (directed_plan[k]) begin
      r = directed_plan[k];
      if (r.is_cfg) begin
        settle_idle();
        write_key_count(r.cfg_val);
      end else begin
        offer(r.it, r.typed, r.want);
      end
    end

    // random part, phase by phase with a new key count each time
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      case (ph)
        0:       cnt = 7'd64;
        1:       cnt = 7'd127;
        2:       cnt = 7'd65;
        3:       cnt = 7'd1;
        4:       cnt = 7'd0;
        5:       cnt = 7'd2;
        6:       cnt = 7'd3;
        default: cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(2, KEYS);
      endcase
      write_key_count(cnt);
      gaps_on   = (ph % 4 == 0) || (ph % 4 == 2);
      stalls_on = (ph % 4 == 0) || (ph % 4 == 3);
      if (ph % 4 == 0) refill_keys();
      // long output stall while items keep coming
      if (ph == 5) begin
        gaps_on = 1'b0;
        hold_asked++;
      end
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) r = row_query(pick_query_time(), 1'b0, '0);
        else r = random_load();
        offer(r.it, 1'b0, '0);
      end
    end

    settle_idle();
    $display("summary: %0d loads and %0d queries sent, %0d results checked",
             n_loads, n_queries, n_checked);
    $display("summary: %0d key_count writes incl. 0, 1, 64 and 127, one long output stall",
             n_cfg);
    if (n_faults == 0 && pending_blends.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/kvi_pkg.sv
rtl/core/kvi_in_if.sv
rtl/core/kvi_out_if.sv
rtl/core/kvi_ram.sv
rtl/core/kvi_div.sv
rtl/core/kvi_lerp.sv
rtl/core/keyframe_vector_interpolation.sv
bench/testbench.sv
